// ===== hw/rtl/sem_pkg.sv =====
// Shared constants, register indexes and control types of the Sobel edge block.
`default_nettype none
package sem_pkg;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int SIZE_W     = 11;
  localparam int CNT_W      = 21;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int PIX_W      = 24;
  localparam int GRAD_W     = 12;
  localparam int SQ_W       = 22;
  localparam int SAT_LIMIT  = 65280;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic accept;
    logic prep;
    logic div_step;
    logic rd;
    logic shift;
    logic grad;
    logic sqr;
    logic root_step;
    logic load_out;
  } sem_cmd_t;

  typedef struct packed {
    logic no_result;
    logic out_busy;
  } sem_sts_t;
endpackage
`default_nettype wire

// ===== hw/rtl/sem_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/sem_ctrl.sv =====
// Sequencer for one item: count restart, column divide, row fetch, gradient, root.
`default_nettype none
module sem_ctrl import sem_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire sem_sts_t sts,
  output sem_cmd_t      cmd
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PREP  = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_SHIFT = 4'd4;
  localparam logic [3:0] S_GRAD  = 4'd5;
  localparam logic [3:0] S_SQR   = 4'd6;
  localparam logic [3:0] S_ROOT  = 4'd7;
  localparam logic [3:0] S_RND   = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic [4:0] step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        step_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 5'd1;
        if (step_r == 5'(CNT_W - 1)) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        state_nxt = sts.no_result ? S_IDLE : S_GRAD;
      end
      S_GRAD: begin
        cmd.grad  = 1'b1;
        state_nxt = S_SQR;
      end
      S_SQR: begin
        cmd.sqr   = 1'b1;
        step_nxt  = '0;
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        step_nxt      = step_r + 5'd1;
        if (step_r == 5'd7) begin
          state_nxt = S_RND;
        end
      end
      S_RND: begin
        // hold until the output slot frees
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/sem_dp.sv =====
// Datapath: size registers, item count, divider, row store, window, gradient, root.
`default_nettype none
module sem_dp import sem_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [SIZE_W-1:0] cfg_data,
  input  wire logic              in_mode,
  input  wire logic [7:0]        in_blue_in,
  input  wire logic [7:0]        in_green_in,
  input  wire logic [7:0]        in_red_in,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             out_blue_edge,
  output logic [7:0]             out_green_edge,
  output logic [7:0]             out_red_edge,
  output logic                   out_frame_end,
  input  wire sem_cmd_t          cmd,
  output sem_sts_t               sts
);
  logic [SIZE_W-1:0] width_r, height_r, w_c, h_c;
  logic [CNT_W-1:0]  pixels_r, cnt_r, t_r, t_nxt;
  logic              mode_r;
  logic [PIX_W-1:0]  pix_in_r, p_r;
  logic [CNT_W-1:0]  div_q_r;
  logic [SIZE_W:0]   div_rem_r, rem_sh, w_ext;
  logic              ge;
  logic [COL_W-1:0]  x_r;
  logic [CNT_W-1:0]  ci;
  logic [SIZE_W-1:0] cj;
  logic              top_ok_r, bot_ok_r, left_ok_r, right_ok_r, no_result_r, fe_r;
  logic [PIX_W-1:0]  win_r [3][3];
  logic [2*PIX_W-1:0] ram_rdata;
  logic signed [GRAD_W-1:0] gx_r [3], gy_r [3];
  logic [15:0]       n_r [3];
  logic              sat_r [3];
  logic [7:0]        q_r [3];
  logic [7:0]        bit_r;
  logic              out_valid_r;
  logic [7:0]        edge_r [3];

  assign w_c = (width_r == '0) ? SIZE_W'(1) :
               ((width_r > SIZE_W'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) : width_r);
  assign h_c = (height_r == '0) ? SIZE_W'(1) :
               ((height_r > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : height_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIZE_W'(MAX_WIDTH);
      height_r <= SIZE_W'(MAX_HEIGHT);
    end else if (cfg_we) begin
      if (cfg_index == REG_WIDTH) begin
        width_r <= cfg_data;
      end else begin
        height_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pixels_r <= CNT_W'(w_c * h_c);
  end

  // restart the count if it lies past the end of the current frame
  assign t_nxt = (cnt_r > pixels_r + CNT_W'(w_c)) ? '0 : cnt_r;

  assign w_ext  = {1'b0, w_c};
  assign rem_sh = {div_rem_r[SIZE_W-1:0], div_q_r[CNT_W-1]};
  assign ge     = rem_sh >= w_ext;

  always_comb begin
    if (div_rem_r == '0) begin
      ci = div_q_r - CNT_W'(2);
      cj = w_c - SIZE_W'(1);
    end else begin
      ci = div_q_r - CNT_W'(1);
      cj = div_rem_r[SIZE_W-1:0] - SIZE_W'(1);
    end
  end

  sem_ram #(.WIDTH(2 * PIX_W), .DEPTH(MAX_WIDTH)) u_rows (
    .clk   (clk),
    .we    (cmd.shift),
    .waddr (x_r),
    .wdata ({ram_rdata[PIX_W-1:0], p_r}),
    .raddr (div_rem_r[COL_W-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else begin
      if (cmd.shift) begin
        cnt_r <= t_r + CNT_W'(1);
        for (int r = 0; r < 3; r++) begin
          win_r[r][0] <= win_r[r][1];
          win_r[r][1] <= win_r[r][2];
        end
        win_r[0][2] <= ram_rdata[2*PIX_W-1:PIX_W];
        win_r[1][2] <= ram_rdata[PIX_W-1:0];
        win_r[2][2] <= p_r;
      end else if (cmd.load_out && fe_r) begin
        cnt_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r   <= in_mode;
      pix_in_r <= {in_red_in, in_green_in, in_blue_in};
    end
    if (cmd.prep) begin
      t_r       <= t_nxt;
      p_r       <= (!mode_r && (t_nxt < pixels_r)) ? pix_in_r : '0;
      div_q_r   <= t_nxt;
      div_rem_r <= '0;
    end
    if (cmd.div_step) begin
      div_rem_r <= ge ? (rem_sh - w_ext) : rem_sh;
      div_q_r   <= {div_q_r[CNT_W-2:0], ge};
    end
    if (cmd.rd) begin
      x_r         <= div_rem_r[COL_W-1:0];
      top_ok_r    <= ci != '0;
      bot_ok_r    <= (ci + CNT_W'(1)) < CNT_W'(h_c);
      left_ok_r   <= cj != '0;
      right_ok_r  <= (cj + SIZE_W'(1)) < w_c;
      no_result_r <= t_r < CNT_W'(w_c) + CNT_W'(1);
      fe_r        <= t_r == pixels_r + CNT_W'(w_c);
    end
  end

  // gradients with out-of-image neighbors dropped
  always_ff @(posedge clk) begin
    logic signed [GRAD_W-1:0] v [3][3];
    logic ok;
    if (cmd.grad) begin
      for (int ch = 0; ch < 3; ch++) begin
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 3; c++) begin
            ok = !((r == 0 && !top_ok_r) || (r == 2 && !bot_ok_r) ||
                   (c == 0 && !left_ok_r) || (c == 2 && !right_ok_r));
            v[r][c] = ok ? $signed({4'd0, win_r[r][c][8*ch +: 8]}) : '0;
          end
        end
        gx_r[ch] <= GRAD_W'(v[0][2] - v[0][0] + 2 * (v[1][2] - v[1][0]) +
                            v[2][2] - v[2][0]);
        gy_r[ch] <= GRAD_W'(v[2][0] - v[0][0] + 2 * (v[2][1] - v[0][1]) +
                            v[2][2] - v[0][2]);
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [SQ_W-1:0] n;
    logic [7:0]      trial;
    logic [15:0]     sq;
    if (cmd.sqr) begin
      for (int ch = 0; ch < 3; ch++) begin
        n = SQ_W'(gx_r[ch] * gx_r[ch]) + SQ_W'(gy_r[ch] * gy_r[ch]);
        sat_r[ch] <= n > SQ_W'(SAT_LIMIT);
        n_r[ch]   <= n[15:0];
        q_r[ch]   <= '0;
      end
      bit_r <= 8'h80;
    end
    if (cmd.root_step) begin
      for (int ch = 0; ch < 3; ch++) begin
        trial = q_r[ch] | bit_r;
        sq    = trial * trial;
        if (sq <= n_r[ch]) begin
          q_r[ch] <= trial;
        end
      end
      bit_r <= bit_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    logic [16:0] lim;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.load_out) begin
      out_frame_end <= fe_r;
      for (int ch = 0; ch < 3; ch++) begin
        lim = 17'(q_r[ch] * q_r[ch]) + 17'(q_r[ch]);
        if (sat_r[ch]) begin
          edge_r[ch] <= 8'hFF;
        end else if (17'(n_r[ch]) > lim && q_r[ch] != 8'hFF) begin
          edge_r[ch] <= q_r[ch] + 8'd1;
        end else begin
          edge_r[ch] <= q_r[ch];
        end
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_blue_edge  = edge_r[0];
  assign out_green_edge = edge_r[1];
  assign out_red_edge   = edge_r[2];
  assign sts.no_result  = no_result_r;
  assign sts.out_busy   = out_valid_r && !out_ready;

`ifndef SYNTHESIS
  a_root_bit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.root_step |-> $onehot(bit_r))
    else $error("root trial bit not one-hot");
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |-> (div_rem_r < w_ext))
    else $error("column remainder not below width");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !(out_valid_r && !out_ready))
    else $error("result loaded over a waiting beat");
`endif
endmodule
`default_nettype wire

// ===== hw/rtl/sobel_edge_magnitude_rgb.sv =====
// From input beat to result valid: restart check, 21-step column divide, row fetch,
// window shift, gradient, square, 8-step root, round. A new item is taken only when
// the last is done, as the serial divider and square root are not pipelined; an item
// without a result ends after the window shift. Results wait in an output register.
// Reset (rst_n low, synchronous): count and window cleared, sizes 1024; the row
// store is not cleared and needs no clearing pass.
`default_nettype none
module sobel_edge_magnitude_rgb import sem_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [SIZE_W-1:0] cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_mode,
  input  wire logic [7:0]        in_blue_in,
  input  wire logic [7:0]        in_green_in,
  input  wire logic [7:0]        in_red_in,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             out_blue_edge,
  output logic [7:0]             out_green_edge,
  output logic [7:0]             out_red_edge,
  output logic                   out_frame_end
);
  sem_cmd_t cmd;
  sem_sts_t sts;

  sem_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sem_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_mode        (in_mode),
    .in_blue_in     (in_blue_in),
    .in_green_in    (in_green_in),
    .in_red_in      (in_red_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_blue_edge  (out_blue_edge),
    .out_green_edge (out_green_edge),
    .out_red_edge   (out_red_edge),
    .out_frame_end  (out_frame_end),
    .cmd            (cmd),
    .sts            (sts)
  );
endmodule
`default_nettype wire

// ===== tb/sobel_edge_magnitude_rgb_tb.sv =====
// Self-checking testbench for the streaming RGB Sobel edge magnitude block.
`default_nettype none
module sobel_edge_magnitude_rgb_tb;
  import sem_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    bit       mode;
    bit [7:0] blue;
    bit [7:0] green;
    bit [7:0] red;
  } pixel_beat_t;

  typedef struct {
    bit [7:0] blue;
    bit [7:0] green;
    bit [7:0] red;
    bit       frame_end;
  } edge_beat_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic              cfg_index = REG_WIDTH;
  logic [SIZE_W-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_mode = 1'b0;
  logic [7:0]        in_blue_in = '0;
  logic [7:0]        in_green_in = '0;
  logic [7:0]        in_red_in = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [7:0]        out_blue_edge;
  logic [7:0]        out_green_edge;
  logic [7:0]        out_red_edge;
  logic              out_frame_end;

  sobel_edge_magnitude_rgb DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state
  bit [SIZE_W-1:0] width_reg = 11'd1024;
  bit [SIZE_W-1:0] height_reg = 11'd1024;
  bit [PIX_W-1:0]  line_mem [2*MAX_WIDTH];
  bit [PIX_W-1:0]  win [3][3];
  bit [CNT_W-1:0]  pos_count = '0;

  pixel_beat_t pending_pixels[$];
  edge_beat_t  expected_edges[$];
  int          mismatches = 0;
  int          items_queued = 0;
  bit          quiet = 1'b0;
  bit          long_hold_req = 1'b0;

  function automatic int clamp_size(int v, int maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  function automatic bit [7:0] round_magnitude(int gx, int gy);
    int n;
    int q;
    n = gx * gx + gy * gy;
    if (n > SAT_LIMIT) return 8'd255;
    q = 0;
    for (int b = 128; b != 0; b >>= 1)
      if ((q | b) * (q | b) <= n) q = q | b;
    if (n > q * q + q) q++;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic void predict_edges(pixel_beat_t it);
    int w;
    int h;
    int pixels;
    int t;
    int x;
    int ctr;
    int ci;
    int cj;
    int gx;
    int gy;
    int v;
    int kx[3][3];
    int ky[3][3];
    bit [PIX_W-1:0] p;
    bit [PIX_W-1:0] top;
    bit [PIX_W-1:0] mid;
    bit [7:0] mag[3];
    edge_beat_t e;
    kx = '{'{-1, 0, 1}, '{-2, 0, 2}, '{-1, 0, 1}};
    ky = '{'{-1, -2, -1}, '{0, 0, 0}, '{1, 2, 1}};
    w = clamp_size(width_reg, MAX_WIDTH);
    h = clamp_size(height_reg, MAX_HEIGHT);
    pixels = w * h;
    t = pos_count;
    // restart when a size change left the count past the frame
    if (t > pixels + w) t = 0;
    p = (!it.mode && t < pixels) ? {it.red, it.green, it.blue} : '0;
    x = t % w;
    top = line_mem[MAX_WIDTH + x];
    mid = line_mem[x];
    line_mem[MAX_WIDTH + x] = mid;
    line_mem[x] = p;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = p;
    if (t < w + 1) begin
      pos_count = CNT_W'(t + 1);
      return;
    end
    ctr = t - w - 1;
    ci = ctr / w;
    cj = ctr % w;
    for (int ch = 0; ch < 3; ch++) begin
      gx = 0;
      gy = 0;
      for (int r = 0; r < 3; r++) begin
        if ((r == 0 && ci == 0) || (r == 2 && ci + 1 >= h)) continue;
        for (int c = 0; c < 3; c++) begin
          if ((c == 0 && cj == 0) || (c == 2 && cj + 1 >= w)) continue;
          v = (win[r][c] >> (8 * ch)) & 8'hFF;
          gx += v * kx[r][c];
          gy += v * ky[r][c];
        end
      end
      mag[ch] = round_magnitude(gx, gy);
    end
    e.blue = mag[0];
    e.green = mag[1];
    e.red = mag[2];
    e.frame_end = (ctr == pixels - 1);
    pos_count = e.frame_end ? '0 : CNT_W'(t + 1);
    expected_edges.push_back(e);
  endfunction

  // Sender
  int send_gap = 0;
  always @(posedge clk) begin
    pixel_beat_t nxt;
    bit took;
    if (rst_n) begin
      took = in_valid && in_ready;
      if (took)
        predict_edges('{in_mode, in_blue_in, in_green_in, in_red_in});
      if (!in_valid || took) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_pixels.size() > 0) begin
          nxt = pending_pixels.pop_front();
          in_valid <= 1'b1;
          in_mode <= nxt.mode;
          in_blue_in <= nxt.blue;
          in_green_in <= nxt.green;
          in_red_in <= nxt.red;
          if (!quiet && $urandom_range(0, 11) == 0) send_gap <= $urandom_range(1, 17);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver
  int recv_gap = 0;
  int long_hold = 0;
  always @(posedge clk) begin
    edge_beat_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_edges.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
        end else begin
          e = expected_edges.pop_front();
          if (e.blue != out_blue_edge || e.green != out_green_edge ||
              e.red != out_red_edge || e.frame_end != out_frame_end) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch at %0t: exp b%0d g%0d r%0d fe%0d got b%0d g%0d r%0d fe%0d",
                       $realtime, e.blue, e.green, e.red, e.frame_end, out_blue_edge,
                       out_green_edge, out_red_edge, out_frame_end);
          end
        end
      end
      if (long_hold_req && long_hold == 0) begin
        long_hold_req <= 1'b0;
        long_hold <= 600;
        out_ready <= 1'b0;
      end else if (long_hold > 0) begin
        long_hold <= long_hold - 1;
        out_ready <= (long_hold == 1);
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        recv_gap <= $urandom_range(0, 16);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic void queue_pixel(bit mode, bit [7:0] b, bit [7:0] g, bit [7:0] r);
    pending_pixels.push_back('{mode, b, g, r});
    items_queued++;
  endfunction

  // Pixels, then flush beats; noise flips the mode now and then.
  task automatic queue_frame(int w, int h, int noise, bit extremes, int cut);
    int wc;
    int total;
    bit [7:0] v;
    wc = clamp_size(w, MAX_WIDTH);
    total = wc * clamp_size(h, MAX_HEIGHT) + wc + 1;
    if (cut > 0 && cut < total) total = cut;
    for (int i = 0; i < total; i++) begin
      v = extremes ? (((i + i / wc) % 2) ? 8'hFF : 8'h00) : 8'($urandom);
      queue_pixel((i >= wc * clamp_size(h, MAX_HEIGHT)) ^ ($urandom_range(0, 99) < noise),
                  extremes ? v : 8'($urandom), extremes ? ~v : 8'($urandom), v);
    end
  endtask

  // settle on falling edges so every clocked update is already visible
  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (pending_pixels.size() != 0 || in_valid || !in_ready ||
               expected_edges.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_size(bit idx, bit [SIZE_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_WIDTH) width_reg = val;
    else height_reg = val;
  endtask

  initial begin
    int w;
    int h;
    int frames;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // reset sizes: a few beats only, then shrink so the count restarts
    queue_pixel(1'b0, 8'hFF, 8'h00, 8'hFF);
    queue_pixel(1'b1, 8'h00, 8'hFF, 8'h00);
    queue_pixel(1'b0, 8'h00, 8'h00, 8'h00);
    queue_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF);
    queue_pixel(1'b0, 8'h55, 8'hAA, 8'h0F);
    queue_pixel(1'b0, 8'hF0, 8'h01, 8'h80);
    wait_idle();
    write_size(REG_WIDTH, 11'd2);
    write_size(REG_HEIGHT, 11'd1);
    queue_frame(2, 1, 0, 1'b1, 0);
    wait_idle();
    write_size(REG_WIDTH, 11'd0);
    write_size(REG_HEIGHT, 11'd0);
    queue_frame(0, 0, 0, 1'b1, 0);
    wait_idle();
    write_size(REG_WIDTH, 11'd3);
    write_size(REG_HEIGHT, 11'd2);
    queue_frame(3, 2, 30, 1'b1, 0);
    wait_idle();
    write_size(REG_WIDTH, 11'd2047);
    write_size(REG_HEIGHT, 11'd2047);
    queue_frame(2047, 2047, 0, 1'b0, 4);
    wait_idle();
    frames = 0;
    while (items_queued < 1050) begin
      if ($urandom_range(0, 9) == 0) w = $urandom_range(16, 40);
      else w = $urandom_range(1, 8);
      h = $urandom_range(1, 6);
      write_size(REG_WIDTH, SIZE_W'(w));
      write_size(REG_HEIGHT, SIZE_W'(h));
      if (items_queued > 930) quiet = 1'b1;
      if (frames == 3) long_hold_req = 1'b1;
      queue_frame(w, h, ($urandom_range(0, 4) == 0) ? 8 : 0, $urandom_range(0, 7) == 0,
                  ($urandom_range(0, 9) == 0) ? $urandom_range(1, w * h) : 0);
      frames++;
      wait_idle();
    end
    if (mismatches == 0 && expected_edges.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
hw/rtl/sem_pkg.sv
hw/rtl/sem_ram.sv
hw/rtl/sem_ctrl.sv
hw/rtl/sem_dp.sv
hw/rtl/sobel_edge_magnitude_rgb.sv
tb/sobel_edge_magnitude_rgb_tb.sv
